// ===== rtl/mrls_pkg.sv =====
// Shared types, codes and saturating arithmetic for the minimal-residual solver.
`timescale 1ns / 1ps
package mrls_pkg;

  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [1:0] REG_SIZE  = 2'd0;
  localparam logic [1:0] REG_MAXIT = 2'd1;
  localparam logic [1:0] REG_TOL   = 2'd2;
  localparam logic [1:0] REG_GUESS = 2'd3;

  localparam logic [1:0] VSEL_B  = 2'd0;
  localparam logic [1:0] VSEL_X  = 2'd1;
  localparam logic [1:0] VSEL_Y  = 2'd2;
  localparam logic [1:0] VSEL_AY = 2'd3;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned DivSteps = 80;

  typedef struct packed {
    logic [4:0]         size;
    logic [7:0]         max_it;
    logic [47:0]        tol;
    logic signed [31:0] guess;
  } cfg_t;

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] mul32(logic signed [31:0] a,
                                               logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p;
  endfunction

endpackage

// ===== rtl/mrls_cfg.sv =====
// APB register file holding the solver configuration.
`timescale 1ns / 1ps
module mrls_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mrls_pkg::CfgAddrW-1:0]   paddr,
  input  logic [63:0]                     pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready,
  output mrls_pkg::cfg_t                  cfg_o
);

  mrls_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]     idx;
  logic           wr;

  assign idx    = paddr[4:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        mrls_pkg::REG_SIZE:  cfg_d.size   = pwdata[4:0];
        mrls_pkg::REG_MAXIT: cfg_d.max_it = pwdata[7:0];
        mrls_pkg::REG_TOL:   cfg_d.tol    = pwdata[47:0];
        mrls_pkg::REG_GUESS: cfg_d.guess  = pwdata[31:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mrls_pkg::REG_SIZE:  prdata = {59'd0, cfg_q.size};
      mrls_pkg::REG_MAXIT: prdata = {56'd0, cfg_q.max_it};
      mrls_pkg::REG_TOL:   prdata = {16'd0, cfg_q.tol};
      mrls_pkg::REG_GUESS: prdata = {32'd0, cfg_q.guess};
      default: prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size   <= 5'd16;
      cfg_q.max_it <= 8'd4;
      cfg_q.tol    <= 48'd28147;
      cfg_q.guess  <= 32'sd2228224;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/mrls_store.sv =====
// Matrix memory and vector memory, one write and one registered read port each.
`timescale 1ns / 1ps
module mrls_store #(
  parameter int unsigned MAX_SIZE = 16,
  parameter int unsigned MAW      = 8,
  parameter int unsigned VAW      = 6
) (
  input  logic                  clk_i,
  input  logic                  mat_we_i,
  input  logic [MAW-1:0]        mat_waddr_i,
  input  logic signed [31:0]    mat_wdata_i,
  input  logic [MAW-1:0]        mat_raddr_i,
  output logic signed [31:0]    mat_rdata_o,
  input  logic                  vec_we_i,
  input  logic [VAW-1:0]        vec_waddr_i,
  input  logic signed [31:0]    vec_wdata_i,
  input  logic [VAW-1:0]        vec_raddr_i,
  output logic signed [31:0]    vec_rdata_o
);

  logic signed [31:0] mat_mem [MAX_SIZE*MAX_SIZE];
  logic signed [31:0] vec_mem [4*MAX_SIZE];

  always_ff @(posedge clk_i) begin
    if (mat_we_i) begin
      mat_mem[mat_waddr_i] <= mat_wdata_i;
    end
    mat_rdata_o <= mat_mem[mat_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (vec_we_i) begin
      vec_mem[vec_waddr_i] <= vec_wdata_i;
    end
    vec_rdata_o <= vec_mem[vec_raddr_i];
  end

endmodule

// ===== rtl/mrls_div.sv =====
// Restoring divider forming the saturated Q16.16 step size from two dot products.
`timescale 1ns / 1ps
module mrls_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [63:0] den_i,
  output logic signed [31:0] tau_o,
  output logic               done_o
);

  localparam int unsigned CW = $clog2(mrls_pkg::DivSteps);

  logic          busy_q, busy_d, fin_q, fin_d, done_q, done_d, neg_q, neg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [63:0]   rem_q, rem_d, d_q, d_d;
  logic [79:0]   dvd_q, dvd_d, quo_q, quo_d;
  logic signed [31:0] tau_q, tau_d;
  logic [64:0]   trial;
  logic          ge;
  logic          hi;

  assign trial  = {rem_q, dvd_q[79]};
  assign ge     = trial >= {1'b0, d_q};
  assign hi     = |quo_q[79:32];
  assign tau_o  = tau_q;
  assign done_o = done_q;

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    d_d    = d_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    tau_d  = tau_q;
    if (start_i) begin
      if (den_i == 64'sd0) begin
        tau_d  = 32'sd0;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        neg_d  = num_i[63];
        cnt_d  = '0;
        rem_d  = 64'd0;
        d_d    = den_i;
        dvd_d  = {(num_i[63] ? 64'(-num_i) : 64'(num_i)), 16'd0};
        quo_d  = 80'd0;
      end
    end else if (busy_q) begin
      rem_d = ge ? 64'(trial - {1'b0, d_q}) : trial[63:0];
      dvd_d = {dvd_q[78:0], 1'b0};
      quo_d = {quo_q[78:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(mrls_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      done_d = 1'b1;
      if (neg_q) begin
        tau_d = (hi || (quo_q[31] && |quo_q[30:0])) ? 32'sh8000_0000
                                                    : 32'(-quo_q[31:0]);
      end else begin
        tau_d = (hi || quo_q[31]) ? 32'sh7FFF_FFFF : quo_q[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    d_q   <= d_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    tau_q <= tau_d;
  end

endmodule

// ===== rtl/minimal_residual_linear_solver.sv =====
// Sequence: a load word is written while idle; a solve sums b.b, scales the tolerance, sets x to
//   the guess, runs passes (update x, form y = Ax - b and Ay, divide), then unloads solution words.
// Throughput: one word at a time; the input stalls from a start word until its last
//   solution word is loaded, set by the single read port of the matrix and vector memories.
// Reset: control clears at once; registers return to 16, 4, 28147 and 34.0; memories hold junk.
`timescale 1ns / 1ps
module minimal_residual_linear_solver #(
  parameter int unsigned MAX_SIZE = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrls_pkg::CfgAddrW-1:0] paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  logic [3:0]                    row_i,
  input  logic [3:0]                    column_i,
  input  logic signed [31:0]            value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [3:0]                    element_index_o,
  output logic signed [31:0]            solution_o,
  output logic                          converged_o,
  output logic [7:0]                    iterations_done_o,
  output logic                          last_o
);

  localparam int unsigned IW  = $clog2(MAX_SIZE);
  localparam int unsigned MAW = $clog2(MAX_SIZE * MAX_SIZE);
  localparam int unsigned VAW = IW + 2;

  typedef enum logic [21:0] {
    S_IDLE     = 22'b1 << 0,
    S_BB_RD    = 22'b1 << 1,
    S_BB_MUL   = 22'b1 << 2,
    S_BB_ACC   = 22'b1 << 3,
    S_TOL      = 22'b1 << 4,
    S_INIT     = 22'b1 << 5,
    S_CHECK    = 22'b1 << 6,
    S_UPD_RDY  = 22'b1 << 7,
    S_UPD_RDX  = 22'b1 << 8,
    S_UPD_WR   = 22'b1 << 9,
    S_MV_RD    = 22'b1 << 10,
    S_MV_MUL   = 22'b1 << 11,
    S_MV_ACC   = 22'b1 << 12,
    S_MV_RDB   = 22'b1 << 13,
    S_MV_FIN   = 22'b1 << 14,
    S_MV_SQ    = 22'b1 << 15,
    S_MV_DOT   = 22'b1 << 16,
    S_DIV_GO   = 22'b1 << 17,
    S_DIV_WAIT = 22'b1 << 18,
    S_CONV     = 22'b1 << 19,
    S_OUT_RD   = 22'b1 << 20,
    S_OUT_LD   = 22'b1 << 21
  } state_e;

  state_e              state_q, state_d;
  mrls_pkg::cfg_t      cfg;
  logic [IW:0]         i_q, i_d, j_q, j_d, n_q, n_d, i_inc, j_inc;
  logic [7:0]          it_q, it_d;
  logic                conv_q, conv_d, phase_q, phase_d;
  logic [1:0]          k_q, k_d;
  logic signed [63:0]  acc_q, acc_d, prod_q, prod_d, p1_q, p1_d, p2_q, p2_d;
  logic signed [63:0]  bb_q, bb_d, yy_q, yy_d, yay_q, yay_d, ayay_q, ayay_d;
  logic signed [31:0]  tau_q, tau_d, val_q, val_d, rd_q, rd_d;
  logic [111:0]        tolbb_q, tolbb_d;
  logic [15:0]         chunk;
  logic                i_last, j_last;

  logic                out_valid_q, out_valid_d, out_load, can_load;
  logic [3:0]          oidx_q;
  logic signed [31:0]  osol_q;
  logic                oconv_q, olast_q;
  logic [7:0]          oit_q;

  logic                mat_we, vec_we;
  logic [MAW-1:0]      mat_waddr, mat_raddr;
  logic [VAW-1:0]      vec_waddr, vec_raddr;
  logic signed [31:0]  mat_wdata, vec_wdata, mat_rdata, vec_rdata;

  logic                div_start, div_done;
  logic signed [31:0]  div_tau;

  mrls_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mrls_store #(.MAX_SIZE(MAX_SIZE), .MAW(MAW), .VAW(VAW)) u_store (
    .clk_i       (clk_i),
    .mat_we_i    (mat_we),
    .mat_waddr_i (mat_waddr),
    .mat_wdata_i (mat_wdata),
    .mat_raddr_i (mat_raddr),
    .mat_rdata_o (mat_rdata),
    .vec_we_i    (vec_we),
    .vec_waddr_i (vec_waddr),
    .vec_wdata_i (vec_wdata),
    .vec_raddr_i (vec_raddr),
    .vec_rdata_o (vec_rdata)
  );

  mrls_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (yay_q),
    .den_i   (ayay_q),
    .tau_o   (div_tau),
    .done_o  (div_done)
  );

  assign i_inc      = i_q + 1'b1;
  assign j_inc      = j_q + 1'b1;
  assign i_last     = i_inc == n_q;
  assign j_last     = j_inc == n_q;
  assign in_stall_o = state_q != S_IDLE;
  assign can_load   = !out_valid_q || !out_stall_i;
  assign div_start  = state_q == S_DIV_GO;

  always_comb begin
    unique case (k_q)
      2'd0:    chunk = bb_q[63:48];
      2'd1:    chunk = bb_q[47:32];
      2'd2:    chunk = bb_q[31:16];
      default: chunk = bb_q[15:0];
    endcase
  end

  always_comb begin
    unique case (state_q)
      S_BB_RD:   vec_raddr = {mrls_pkg::VSEL_B, i_q[IW-1:0]};
      S_UPD_RDY: vec_raddr = {mrls_pkg::VSEL_Y, i_q[IW-1:0]};
      S_MV_RD:   vec_raddr = {(phase_q ? mrls_pkg::VSEL_Y : mrls_pkg::VSEL_X), j_q[IW-1:0]};
      S_MV_RDB:  vec_raddr = {(phase_q ? mrls_pkg::VSEL_Y : mrls_pkg::VSEL_B), i_q[IW-1:0]};
      default:   vec_raddr = {mrls_pkg::VSEL_X, i_q[IW-1:0]};
    endcase
  end

  assign mat_raddr = MAW'(32'(i_q[IW-1:0]) * MAX_SIZE + 32'(j_q[IW-1:0]));
  assign mat_waddr = MAW'(32'(row_i) * MAX_SIZE + 32'(column_i));
  assign mat_wdata = value_i;
  assign mat_we    = state_q == S_IDLE && in_valid_i && mode_i == mrls_pkg::MODE_LOAD_A &&
                     32'(row_i) < MAX_SIZE && 32'(column_i) < MAX_SIZE;

  always_comb begin
    vec_we    = 1'b0;
    vec_waddr = {mrls_pkg::VSEL_X, i_q[IW-1:0]};
    vec_wdata = cfg.guess;
    unique case (state_q)
      S_IDLE: begin
        vec_we    = in_valid_i && mode_i == mrls_pkg::MODE_LOAD_B && 32'(row_i) < MAX_SIZE;
        vec_waddr = {mrls_pkg::VSEL_B, IW'(row_i)};
        vec_wdata = value_i;
      end
      S_INIT: vec_we = 1'b1;
      S_UPD_WR: begin
        vec_we    = 1'b1;
        vec_wdata = mrls_pkg::sat32(64'(vec_rdata) - (prod_q >>> 16));
      end
      S_MV_FIN: begin
        vec_we    = 1'b1;
        vec_waddr = {(phase_q ? mrls_pkg::VSEL_AY : mrls_pkg::VSEL_Y), i_q[IW-1:0]};
        vec_wdata = val_d;
      end
      default: vec_we = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    i_d = i_q;      j_d = j_q;      n_d = n_q;
    it_d = it_q;    conv_d = conv_q; phase_d = phase_q; k_d = k_q;
    acc_d = acc_q;  prod_d = prod_q; p1_d = p1_q; p2_d = p2_q;
    bb_d = bb_q;    yy_d = yy_q;    yay_d = yay_q; ayay_d = ayay_q;
    tau_d = tau_q;  rd_d = rd_q;    tolbb_d = tolbb_q;
    val_d = phase_q ? mrls_pkg::sat32(acc_q)
                    : mrls_pkg::sat32(acc_q - 64'(vec_rdata));
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && mode_i == mrls_pkg::MODE_START) begin
          if (cfg.size == 5'd0) begin
            n_d = (IW+1)'(1);
          end else if (32'(cfg.size) > MAX_SIZE) begin
            n_d = (IW+1)'(MAX_SIZE);
          end else begin
            n_d = (IW+1)'(cfg.size);
          end
          i_d     = '0;
          bb_d    = 64'sd0;
          state_d = S_BB_RD;
        end
      end
      S_BB_RD:  state_d = S_BB_MUL;
      S_BB_MUL: begin
        prod_d  = mrls_pkg::mul32(vec_rdata, vec_rdata);
        state_d = S_BB_ACC;
      end
      S_BB_ACC: begin
        bb_d = mrls_pkg::sat_add64(bb_q, prod_q);
        i_d  = i_inc;
        if (i_last) begin
          k_d     = 2'd0;
          tolbb_d = 112'd0;
          state_d = S_TOL;
        end else begin
          state_d = S_BB_RD;
        end
      end
      S_TOL: begin
        tolbb_d = (tolbb_q << 16) + 112'(cfg.tol) * 112'(chunk);
        k_d     = k_q + 1'b1;
        if (k_q == 2'd3) begin
          i_d     = '0;
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        i_d = i_inc;
        if (i_last) begin
          it_d    = 8'd0;
          conv_d  = 1'b0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        i_d = '0;
        j_d = '0;
        if (conv_q || it_q >= cfg.max_it) begin
          state_d = S_OUT_RD;
        end else if (it_q != 8'd0) begin
          state_d = S_UPD_RDY;
        end else begin
          phase_d = 1'b0;
          acc_d   = 64'sd0;
          yy_d    = 64'sd0;
          state_d = S_MV_RD;
        end
      end
      S_UPD_RDY: state_d = S_UPD_RDX;
      S_UPD_RDX: begin
        prod_d  = mrls_pkg::mul32(tau_q, vec_rdata);
        state_d = S_UPD_WR;
      end
      S_UPD_WR: begin
        if (i_last) begin
          i_d     = '0;
          j_d     = '0;
          phase_d = 1'b0;
          acc_d   = 64'sd0;
          yy_d    = 64'sd0;
          state_d = S_MV_RD;
        end else begin
          i_d     = i_inc;
          state_d = S_UPD_RDY;
        end
      end
      S_MV_RD:  state_d = S_MV_MUL;
      S_MV_MUL: begin
        prod_d  = mrls_pkg::mul32(mat_rdata, vec_rdata);
        state_d = S_MV_ACC;
      end
      S_MV_ACC: begin
        acc_d = acc_q + (prod_q >>> 16);
        if (j_last) begin
          j_d     = '0;
          state_d = S_MV_RDB;
        end else begin
          j_d     = j_inc;
          state_d = S_MV_RD;
        end
      end
      S_MV_RDB: state_d = S_MV_FIN;
      S_MV_FIN: begin
        rd_d    = vec_rdata;
        state_d = S_MV_SQ;
      end
      S_MV_SQ: begin
        p1_d    = mrls_pkg::mul32(val_q, val_q);
        p2_d    = mrls_pkg::mul32(rd_q, val_q);
        state_d = S_MV_DOT;
      end
      S_MV_DOT: begin
        if (phase_q) begin
          ayay_d = mrls_pkg::sat_add64(ayay_q, p1_q);
          yay_d  = mrls_pkg::sat_add64(yay_q, p2_q);
        end else begin
          yy_d   = mrls_pkg::sat_add64(yy_q, p1_q);
        end
        acc_d = 64'sd0;
        j_d   = '0;
        if (!i_last) begin
          i_d     = i_inc;
          state_d = S_MV_RD;
        end else if (!phase_q) begin
          i_d     = '0;
          phase_d = 1'b1;
          ayay_d  = 64'sd0;
          yay_d   = 64'sd0;
          state_d = S_MV_RD;
        end else begin
          state_d = S_DIV_GO;
        end
      end
      S_DIV_GO: state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          tau_d   = div_tau;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        conv_d  = {1'b0, yy_q[62:0], 48'd0} < tolbb_q;
        it_d    = it_q + 1'b1;
        state_d = S_CHECK;
      end
      S_OUT_RD: state_d = S_OUT_LD;
      S_OUT_LD: begin
        if (can_load) begin
          out_load = 1'b1;
          if (i_last) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_inc;
            state_d = S_OUT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= (IW+1)'(1);
      it_q        <= 8'd0;
      conv_q      <= 1'b0;
      phase_q     <= 1'b0;
      k_q         <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      n_q         <= n_d;
      it_q        <= it_d;
      conv_q      <= conv_d;
      phase_q     <= phase_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    p1_q    <= p1_d;
    p2_q    <= p2_d;
    bb_q    <= bb_d;
    yy_q    <= yy_d;
    yay_q   <= yay_d;
    ayay_q  <= ayay_d;
    tau_q   <= tau_d;
    rd_q    <= rd_d;
    tolbb_q <= tolbb_d;
    if (state_q == S_MV_FIN) begin
      val_q <= val_d;
    end
    if (out_load) begin
      oidx_q  <= 4'(i_q);
      osol_q  <= vec_rdata;
      oconv_q <= conv_q;
      oit_q   <= it_q;
      olast_q <= i_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign element_index_o   = oidx_q;
  assign solution_o        = osol_q;
  assign converged_o       = oconv_q;
  assign iterations_done_o = oit_q;
  assign last_o            = olast_q;

  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> n_q >= (IW+1)'(1) && 32'(n_q) <= MAX_SIZE)
    else $error("system order out of range during solve");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV_WAIT)
    else $error("step size ready outside wait state");

  a_conv_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(conv_q) |-> $past(state_q) == S_CONV)
    else $error("converged flag set outside the test");

  a_it_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT_LD |-> it_q <= cfg.max_it)
    else $error("pass count above limit");

  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> state_q == S_OUT_LD && i_q < n_q)
    else $error("solution word loaded out of sequence");

endmodule

// ===== bench/minimal_residual_linear_solver_checker.sv =====
// Checker for the minimal-residual solver: predicts every solution word and compares.
`timescale 1ns / 1ps
module minimal_residual_linear_solver_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         mode_i,
  input  logic [3:0]         row_i,
  input  logic [3:0]         column_i,
  input  logic signed [31:0] value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [3:0]         element_index_i,
  input  logic signed [31:0] solution_i,
  input  logic               converged_i,
  input  logic [7:0]         iterations_done_i,
  input  logic               last_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 solves_o,
  output int                 words_o
);

  typedef struct {
    logic [3:0]         idx;
    logic signed [31:0] sol;
    logic               conv;
    logic [7:0]         iters;
    logic               last;
  } sol_word_t;

  sol_word_t          sol_q[$];
  logic signed [31:0] mat_m[16][16];
  logic signed [31:0] rhs_m[16];
  logic signed [31:0] x_m[16];
  logic signed [31:0] y_m[16];
  logic signed [31:0] ay_m[16];
  logic [4:0]         size_r;
  logic [7:0]         maxit_r;
  logic [47:0]        tol_r;
  logic signed [31:0] guess_r;

  function automatic longint sadd(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? 64'h8000_0000_0000_0000 :
                                                      64'h7FFF_FFFF_FFFF_FFFF;
    return s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint prod_q16(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 16;
  endfunction

  function automatic logic signed [31:0] tau_of(longint num, longint den);
    logic [63:0] mag;
    logic [63:0] d;
    logic [79:0] q;
    if (den <= 0) return 32'sd0;
    mag = num < 0 ? -num : num;
    d = den;
    if (mag / d >= 64'd65536) q = 80'h1_0000_0000;
    else q = {mag, 16'h0} / {16'h0, d};
    if (num < 0) begin
      if (q > 80'h8000_0000) q = 80'h8000_0000;
      return -q[31:0];
    end
    if (q > 80'h7FFF_FFFF) q = 80'h7FFF_FFFF;
    return q[31:0];
  endfunction

  task automatic solve_system();
    int          n;
    int          it;
    longint      bb, yy, yay, ayay, acc;
    logic signed [31:0] tau;
    logic        conv;
    logic [127:0] lhs, rhs;
    sol_word_t   w;
    n = size_r == 0 ? 1 : (size_r > 16 ? 16 : int'(size_r));
    bb = 0;
    tau = 0;
    conv = 0;
    for (int i = 0; i < n; i++) bb = sadd(bb, longint'(rhs_m[i]) * longint'(rhs_m[i]));
    for (int i = 0; i < n; i++) x_m[i] = guess_r;
    it = 0;
    while (!conv && it < maxit_r) begin
      if (it != 0)
        for (int i = 0; i < n; i++) x_m[i] = clamp32(longint'(x_m[i]) - prod_q16(tau, y_m[i]));
      yy = 0;
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j < n; j++) acc += prod_q16(mat_m[i][j], x_m[j]);
        y_m[i] = clamp32(acc - longint'(rhs_m[i]));
        yy = sadd(yy, longint'(y_m[i]) * longint'(y_m[i]));
      end
      yay = 0;
      ayay = 0;
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j < n; j++) acc += prod_q16(mat_m[i][j], y_m[j]);
        ay_m[i] = clamp32(acc);
        ayay = sadd(ayay, longint'(ay_m[i]) * longint'(ay_m[i]));
        yay = sadd(yay, longint'(y_m[i]) * longint'(ay_m[i]));
      end
      tau = tau_of(yay, ayay);
      lhs = {16'h0, yy, 48'h0};
      rhs = {80'h0, tol_r} * {64'h0, bb};
      conv = lhs < rhs;
      it++;
    end
    for (int i = 0; i < n; i++) begin
      w.idx = 4'(i);
      w.sol = x_m[i];
      w.conv = conv;
      w.iters = 8'(it);
      w.last = (i + 1 == n);
      sol_q.push_back(w);
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    solves_o = 0;
    words_o = 0;
    pending_o = 0;
    size_r = 16;
    maxit_r = 4;
    tol_r = 28147;
    guess_r = 2228224;
  end

  always @(posedge clk_i) begin
    sol_word_t w;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          mrls_pkg::REG_SIZE:  size_r = pwdata[4:0];
          mrls_pkg::REG_MAXIT: maxit_r = pwdata[7:0];
          mrls_pkg::REG_TOL:   tol_r = pwdata[47:0];
          mrls_pkg::REG_GUESS: guess_r = pwdata[31:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (mode_i)
          mrls_pkg::MODE_LOAD_A: mat_m[row_i][column_i] = value_i;
          mrls_pkg::MODE_LOAD_B: rhs_m[row_i] = value_i;
          mrls_pkg::MODE_START: begin
            solve_system();
            solves_o++;
          end
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        words_o++;
        if (sol_q.size() == 0) begin
          report("unexpected word, index", element_index_i, -1);
        end else begin
          w = sol_q.pop_front();
          if (element_index_i !== w.idx) report("element_index", element_index_i, w.idx);
          if (solution_i !== w.sol) report("solution", solution_i, w.sol);
          if (converged_i !== w.conv) report("converged", converged_i, w.conv);
          if (iterations_done_i !== w.iters)
            report("iterations_done", iterations_done_i, w.iters);
          if (last_i !== w.last) report("last", last_i, w.last);
        end
      end
      pending_o = sol_q.size();
    end
  end
endmodule

// ===== bench/minimal_residual_linear_solver_tb.sv =====
// Testbench top for the minimal-residual solver: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module minimal_residual_linear_solver_tb;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [4:0]         paddr = 0;
  logic [63:0]        pwdata = 0;
  logic [63:0]        prdata;
  logic               pready;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic [1:0]         mode_i = 0;
  logic [3:0]         row_i = 0, column_i = 0;
  logic signed [31:0] value_i = 0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic [3:0]         element_index_o;
  logic signed [31:0] solution_o;
  logic               converged_o;
  logic [7:0]         iterations_done_o;
  logic               last_o;
  int                 errors, pending, solves, words;
  int                 items_sent;
  logic               hold_req = 0;

  minimal_residual_linear_solver dut (.*);

  minimal_residual_linear_solver_checker chk (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid_i, .in_stall_i(in_stall_o), .mode_i, .row_i, .column_i, .value_i,
    .out_valid_i(out_valid_o), .out_stall_i, .element_index_i(element_index_o),
    .solution_i(solution_o), .converged_i(converged_o),
    .iterations_done_i(iterations_done_o), .last_i(last_o),
    .errors_o(errors), .pending_o(pending), .solves_o(solves), .words_o(words)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #40_000_000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: stall patterns, with a long hold on request
  initial begin
    int style;
    int phase;
    forever begin
      style = $urandom_range(0, 3);
      for (int k = 0; k < 64; k++) begin
        @(negedge clk_i);
        if (hold_req) begin
          for (int h = 0; h < 2000; h++) begin
            out_stall_i <= 1;
            @(negedge clk_i);
          end
          hold_req = 0;
        end
        phase++;
        case (style)
          0: out_stall_i <= 0;
          1: out_stall_i <= ($urandom_range(0, 1) == 1);
          2: out_stall_i <= (phase % 5 < 2);
          default: out_stall_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [63:0] data);
    @(negedge clk_i);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic put_word(logic [1:0] m, logic [3:0] r, logic [3:0] c, logic [31:0] v);
    @(negedge clk_i);
    in_valid_i <= 1;
    mode_i <= m;
    row_i <= r;
    column_i <= c;
    value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if ($urandom_range(0, 2) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_all(logic [4:0] sz, logic [7:0] mi, logic [47:0] tol, logic [31:0] g);
    drain();
    cfg_write(mrls_pkg::REG_SIZE, 64'(sz));
    cfg_write(mrls_pkg::REG_MAXIT, 64'(mi));
    cfg_write(mrls_pkg::REG_TOL, 64'(tol));
    cfg_write(mrls_pkg::REG_GUESS, {{32{g[31]}}, g});
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
    endcase
  endfunction

  initial begin
    int n;
    int mi;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1;
    // fill the whole system, diagonally dominant
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 16; j++)
        put_word(mrls_pkg::MODE_LOAD_A, 4'(i), 4'(j),
                 i == j ? 32'h0004_0000 : $urandom_range(0, 32'h2000));
      put_word(mrls_pkg::MODE_LOAD_B, 4'(i), 4'd0, $urandom_range(0, 32'h0002_0000));
    end
    put_word(mrls_pkg::MODE_START, 4'd0, 4'd0, 32'd0);
    put_word(mrls_pkg::MODE_NONE, 4'hF, 4'hF, 32'hFFFF_FFFF);
    set_all(5'd0, 8'd255, 48'hFFFF_FFFF_FFFF, 32'h8000_0000);
    put_word(mrls_pkg::MODE_START, 4'd0, 4'd0, 32'd0);
    put_word(mrls_pkg::MODE_LOAD_A, 4'd0, 4'd0, 32'h7FFF_FFFF);
    put_word(mrls_pkg::MODE_LOAD_B, 4'd0, 4'd0, 32'h8000_0000);
    put_word(mrls_pkg::MODE_START, 4'd0, 4'd0, 32'd0);
    set_all(5'd1, 8'd0, 48'd0, 32'h7FFF_FFFF);
    put_word(mrls_pkg::MODE_START, 4'd0, 4'd0, 32'd0);
    set_all(5'd1, 8'd5, 48'hFFFF_FFFF_FFFF, 32'h0001_0000);
    put_word(mrls_pkg::MODE_LOAD_A, 4'd0, 4'd0, 32'd0);
    put_word(mrls_pkg::MODE_START, 4'd0, 4'd0, 32'd0);
    put_word(mrls_pkg::MODE_LOAD_A, 4'd0, 4'd0, 32'h0002_0000);
    put_word(mrls_pkg::MODE_LOAD_B, 4'd0, 4'd0, 32'd0);
    put_word(mrls_pkg::MODE_START, 4'd0, 4'd0, 32'd0);
    put_word(mrls_pkg::MODE_LOAD_B, 4'd0, 4'd0, 32'h0004_0000);
    put_word(mrls_pkg::MODE_START, 4'd0, 4'd0, 32'd0);
    set_all(5'd31, 8'd2, 48'd28147, 32'd2228224);
    put_word(mrls_pkg::MODE_START, 4'd0, 4'd0, 32'd0);
    set_all(5'd2, 8'd3, 48'd28147, 32'd2228224);
    hold_req = 1;
    put_word(mrls_pkg::MODE_START, 4'd0, 4'd0, 32'd0);
    put_word(mrls_pkg::MODE_LOAD_A, 4'd1, 4'd1, 32'h0003_0000);
    put_word(mrls_pkg::MODE_START, 4'd0, 4'd0, 32'd0);
    put_word(mrls_pkg::MODE_LOAD_B, 4'd1, 4'd0, 32'h0001_0000);

    for (int p = 0; p < 12; p++) begin
      n = $urandom_range(0, 4) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 6);
      mi = n > 6 ? $urandom_range(0, 2) : $urandom_range(0, 20);
      set_all(5'(n), 8'(mi),
              $urandom_range(0, 1) ? 48'({$urandom(), $urandom()}) :
                                     48'($urandom_range(0, 1 << 20)),
              rand_value());
      if (n == 0) n = 1;
      if (n > 16) n = 16;
      if (p == 6) hold_req = 1;
      for (int s = 0; s < 6; s++) begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 9) == 0)
            put_word(2'($urandom_range(0, 3)), 4'($urandom()), 4'($urandom()), $urandom());
          else if ($urandom_range(0, 3) == 0)
            put_word(mrls_pkg::MODE_LOAD_B, 4'($urandom_range(0, n - 1)), 4'($urandom()),
                     rand_value());
          else
            put_word(mrls_pkg::MODE_LOAD_A, 4'($urandom_range(0, n - 1)),
                     4'($urandom_range(0, n - 1)), rand_value());
        end
        put_word(mrls_pkg::MODE_START, 4'($urandom()), 4'($urandom()), $urandom());
        if ($urandom_range(0, 3) == 0) drain();
      end
    end

    drain();
    repeat (100) @(negedge clk_i);
    $display("covered %0d input words, %0d solves, %0d solution words checked",
             items_sent, solves, words);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
